@@ hdl/ppsbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ppsbm_pkg;

  localparam int MaxBankBytes = 32768;
  localparam int FillLimit    = 32768;
  localparam int EffLimit     = (MaxBankBytes > FillLimit) ? FillLimit : MaxBankBytes;

  localparam int SizeW  = 16;
  localparam int FillW  = 15;
  localparam int TotalW = 32;
  localparam int CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] RegBankASize = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegBankBSize = CfgIdxW'(1);
  localparam logic [SizeW-1:0]   BankSizeReset = SizeW'(2048);

  typedef enum logic [1:0] {
    CmdWrite    = 2'd0,
    CmdSendReq  = 2'd1,
    CmdSendDone = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    BankIdle = 2'd0,
    BankHold = 2'd1,
    BankFull = 2'd2,
    BankSend = 2'd3
  } bank_state_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatRetry    = 3'd1,
    StatTooLarge = 3'd2,
    StatNoSend   = 3'd3,
    StatIgnored  = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [SizeW-1:0] chunk_length;
    logic             done_bank;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic              bank;
    logic [FillW-1:0]  offset;
    logic [FillW-1:0]  length;
    logic [TotalW-1:0] sent_total;
  } result_t;

  // clamp a programmed size to what the fill counter can hold
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] lim;
    lim = SizeW'(EffLimit);
    eff_size = (size > lim) ? lim : size;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ppsbm_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ppsbm_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ppsbm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ppsbm_pkg::SizeW-1:0]  cfg_data_i,
  input  wire logic                         fire_i,
  input  wire ppsbm_pkg::item_t             item_i,
  output ppsbm_pkg::result_t                res_o
);
  import ppsbm_pkg::*;

  logic [SizeW-1:0]  size_a_q, size_b_q;
  logic [FillW-1:0]  fill_q [2];
  logic [FillW-1:0]  fill_d [2];
  bank_state_e       state_q [2];
  bank_state_e       state_d [2];
  logic              fill_side_q, fill_side_d;
  logic              send_valid_q, send_valid_d;
  logic              send_bank_q, send_bank_d;
  logic [TotalW-1:0] total_q, total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_a_q <= BankSizeReset;
      size_b_q <= BankSizeReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegBankASize) size_a_q <= cfg_data_i;
      if (cfg_index_i == RegBankBSize) size_b_q <= cfg_data_i;
    end
  end

  always_comb begin
    logic [SizeW-1:0] eff [2];
    logic             idx;
    logic             placed;
    logic [FillW+1:0] need;
    eff[0]       = eff_size(size_a_q);
    eff[1]       = eff_size(size_b_q);
    fill_d       = fill_q;
    state_d      = state_q;
    fill_side_d  = fill_side_q;
    send_valid_d = send_valid_q;
    send_bank_d  = send_bank_q;
    total_d      = total_q;
    res_o        = '0;
    res_o.status = StatIgnored;
    placed       = 1'b0;
    need         = '0;
    idx          = 1'b0;
    case (item_i.command)
      CmdWrite: begin
        if (item_i.chunk_length >= eff[0]) begin
          res_o.status = StatTooLarge;
        end else begin
          res_o.status = StatRetry;
          idx = fill_side_q;
          for (int i = 0; i < 2; i++) begin
            if (!placed) begin
              if (state_d[idx] != BankSend && state_d[idx] != BankFull) begin
                need = {2'b00, fill_d[idx]} + {1'b0, item_i.chunk_length};
                if (need >= {1'b0, eff[idx]}) begin
                  // no room: close this bank and move filling across
                  state_d[idx] = BankFull;
                  if (!send_valid_d) begin
                    send_valid_d = 1'b1;
                    send_bank_d  = idx;
                  end
                  idx         = ~idx;
                  fill_side_d = idx;
                end else begin
                  res_o.offset = fill_d[idx];
                  fill_d[idx]  = need[FillW-1:0];
                  state_d[idx] = BankHold;
                  res_o.status = StatOk;
                  res_o.bank   = idx;
                  placed       = 1'b1;
                end
              end else begin
                idx = ~idx;
              end
            end
          end
        end
      end
      CmdSendReq: begin
        res_o.status = StatNoSend;
        idx = send_valid_q ? send_bank_q : fill_side_q;
        for (int i = 0; i < 2; i++) begin
          if (!placed) begin
            if (state_q[idx] != BankIdle) begin
              state_d[idx] = BankSend;
              send_valid_d = 1'b1;
              send_bank_d  = idx;
              if (fill_side_q == idx) fill_side_d = ~idx;
              res_o.status = StatOk;
              res_o.bank   = idx;
              res_o.length = fill_q[idx];
              placed       = 1'b1;
            end else begin
              idx = ~idx;
            end
          end
        end
      end
      CmdSendDone: begin
        if (send_valid_q && send_bank_q == item_i.done_bank) begin
          total_d = total_q + TotalW'(fill_q[item_i.done_bank]);
          fill_d[item_i.done_bank]  = '0;
          state_d[item_i.done_bank] = BankIdle;
          send_valid_d = 1'b0;
          res_o.status = StatOk;
          res_o.bank   = item_i.done_bank;
        end
      end
      default: begin
        res_o.status = StatIgnored;
      end
    endcase
    res_o.sent_total = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q[0]    <= '0;
      fill_q[1]    <= '0;
      state_q[0]   <= BankIdle;
      state_q[1]   <= BankIdle;
      fill_side_q  <= 1'b0;
      send_valid_q <= 1'b0;
      send_bank_q  <= 1'b0;
      total_q      <= '0;
    end else if (fire_i) begin
      fill_q       <= fill_d;
      state_q      <= state_d;
      fill_side_q  <= fill_side_d;
      send_valid_q <= send_valid_d;
      send_bank_q  <= send_bank_d;
      total_q      <= total_d;
    end
  end

  // the send candidate never points at an idle bank
  a_cand_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_valid_q |-> state_q[send_bank_q] != BankIdle)
    else $error("send candidate bank is idle");

  // a bank in transmission is always the tracked candidate
  a_send0_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q[0] == BankSend |-> (send_valid_q && send_bank_q == 1'b0))
    else $error("bank 0 sending but not tracked");

  a_send1_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q[1] == BankSend |-> (send_valid_q && send_bank_q == 1'b1))
    else $error("bank 1 sending but not tracked");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q[0] != BankIdle || fill_q[0] == '0) && (state_q[1] != BankIdle || fill_q[1] == '0))
    else $error("idle bank holds a nonzero fill");

  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && item_i.command == CmdSendDone) |=> $stable(total_q))
    else $error("sent total moved without a send complete");

endmodule

`default_nettype wire

@@ hdl/ping_pong_send_bank_manager.sv @@
// Ping-pong transmit bank manager: tracks the fill level and status of two
// transmit banks. Each input item is a write chunk, a send request or a send
// complete, and produces exactly one result item. One item is taken every
// clock cycle when the output side keeps up. An item passes two registers:
// the accepting edge loads the input register, and the edge on which the
// output side can advance updates the bank state and loads the result
// register, which presents the result. The user must write bank sizes
// through the configuration channel only while the block is idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module ping_pong_send_bank_manager (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [ppsbm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ppsbm_pkg::SizeW-1:0]   cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [23:0]                   s_axis_tdata,  // chunk_length, done_bank
  input  wire logic [1:0]                    s_axis_tuser,  // command
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [63:0]                   m_axis_tdata,  // bank, offset, length, sent_total
  output      logic [2:0]                    m_axis_tuser   // status
);
  import ppsbm_pkg::*;

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    advance;
  logic    fire;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign fire          = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.command      <= cmd_e'(s_axis_tuser);
      in_q.chunk_length <= s_axis_tdata[15:0];
      in_q.done_bank    <= s_axis_tdata[16];
    end
    if (fire) out_q <= res;
  end

  ppsbm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (in_q),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {1'b0, out_q.sent_total, out_q.length, out_q.offset, out_q.bank};

endmodule

`default_nettype wire
